// ----- sv/ifreq_pkg.sv -----
// Shared types and constants of the I/Q instantaneous frequency block.
package ifreq_pkg;

    // Angle accumulator: 2^31 stands for pi, two guard bits above the sign.
    localparam int Z_WIDTH  = 34;
    localparam int ATAN_LEN = 24;

    localparam logic signed [Z_WIDTH-1:0] QUARTER_TURN = 34'sd1073741824;

    // round(atan(2^-k) * 2^31 / pi)
    localparam logic [31:0] ATAN_TAB [ATAN_LEN] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    // Control that rides along with each pipeline slot.
    typedef struct packed {
        logic valid;   // slot carries a transaction
        logic phase;   // a phase step result is owed
        logic close;   // a closing result is owed
        logic zero;    // the product was zero
    } ctl_t;

endpackage

// ----- sv/ifreq_front.sv -----
// Front end: previous-sample hold, conjugate product and quadrant pre-rotation.
module ifreq_front #(
    parameter int S = 16,
    parameter int W = 2 * S + 3
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  en,
    input  logic                                  accept,
    input  logic signed [S-1:0]                   cur_i,
    input  logic signed [S-1:0]                   cur_q,
    input  logic                                  cur_end,
    output ifreq_pkg::ctl_t                       ctl_o,
    output logic signed [W-1:0]                   x_o,
    output logic signed [W-1:0]                   y_o,
    output logic signed [ifreq_pkg::Z_WIDTH-1:0]  z_o
);

    localparam int ZW = ifreq_pkg::Z_WIDTH;

    logic signed [S-1:0]   prev_i_reg, prev_q_reg;
    logic                  have_prev_reg;

    logic signed [2*S-1:0] p_ii_reg, p_qq_reg, p_iq_reg, p_qi_reg;
    ifreq_pkg::ctl_t       ctl1_reg, ctl1_next;

    logic signed [W-1:0]   t_re_reg, t_im_reg;
    ifreq_pkg::ctl_t       ctl2_reg;

    logic signed [W-1:0]   x_reg, y_reg, x_next, y_next;
    logic signed [ZW-1:0]  z_reg, z_next;
    ifreq_pkg::ctl_t       ctl3_reg, ctl3_next;

    always_comb begin
        ctl1_next       = '0;
        ctl1_next.phase = accept && have_prev_reg;
        ctl1_next.close = accept && cur_end;
        ctl1_next.valid = ctl1_next.phase || ctl1_next.close;
    end

    // Rotate the left half plane into the right one before the vectoring steps.
    always_comb begin
        x_next = t_re_reg;
        y_next = t_im_reg;
        z_next = '0;
        if (t_re_reg < 0) begin
            if (t_im_reg >= 0) begin
                x_next = t_im_reg;
                y_next = -t_re_reg;
                z_next = ifreq_pkg::QUARTER_TURN;
            end else begin
                x_next = -t_im_reg;
                y_next = t_re_reg;
                z_next = -ifreq_pkg::QUARTER_TURN;
            end
        end
        ctl3_next      = ctl2_reg;
        ctl3_next.zero = (t_re_reg == '0) && (t_im_reg == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_prev_reg <= 1'b0;
            ctl1_reg      <= '0;
            ctl2_reg      <= '0;
            ctl3_reg      <= '0;
        end else if (en) begin
            if (accept) begin
                have_prev_reg <= !cur_end;
            end
            ctl1_reg <= ctl1_next;
            ctl2_reg <= ctl1_reg;
            ctl3_reg <= ctl3_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            if (accept) begin
                prev_i_reg <= cur_end ? '0 : cur_i;
                prev_q_reg <= cur_end ? '0 : cur_q;
            end
            p_ii_reg <= cur_i * prev_i_reg;
            p_qq_reg <= cur_q * prev_q_reg;
            p_iq_reg <= prev_i_reg * cur_q;
            p_qi_reg <= cur_i * prev_q_reg;
            t_re_reg <= W'(p_ii_reg) + W'(p_qq_reg);
            t_im_reg <= W'(p_iq_reg) - W'(p_qi_reg);
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
        end
    end

    assign ctl_o = ctl3_reg;
    assign x_o   = x_reg;
    assign y_o   = y_reg;
    assign z_o   = z_reg;

endmodule

// ----- sv/ifreq_cordic_cell.sv -----
// One CORDIC vectoring step as a pipeline cell with its own shift and angle.
module ifreq_cordic_cell #(
    parameter int W     = 35,
    parameter int SHIFT = 0
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  en,
    input  ifreq_pkg::ctl_t                       ctl_i,
    input  logic signed [W-1:0]                   x_i,
    input  logic signed [W-1:0]                   y_i,
    input  logic signed [ifreq_pkg::Z_WIDTH-1:0]  z_i,
    output ifreq_pkg::ctl_t                       ctl_o,
    output logic signed [W-1:0]                   x_o,
    output logic signed [W-1:0]                   y_o,
    output logic signed [ifreq_pkg::Z_WIDTH-1:0]  z_o
);

    localparam int ZW = ifreq_pkg::Z_WIDTH;
    localparam logic signed [ZW-1:0] STEP_ANGLE = ZW'(ifreq_pkg::ATAN_TAB[SHIFT]);

    logic signed [W-1:0]  xs, ys;
    logic signed [W-1:0]  x_reg, y_reg, x_next, y_next;
    logic signed [ZW-1:0] z_reg, z_next;
    ifreq_pkg::ctl_t      ctl_reg;

    assign xs = x_i >>> SHIFT;
    assign ys = y_i >>> SHIFT;

    // Drive y toward zero; the rotation direction follows the sign of y.
    always_comb begin
        if (y_i > 0) begin
            x_next = x_i + ys;
            y_next = y_i - xs;
            z_next = z_i + STEP_ANGLE;
        end else begin
            x_next = x_i - ys;
            y_next = y_i + xs;
            z_next = z_i - STEP_ANGLE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (en) begin
            ctl_reg <= ctl_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign ctl_o = ctl_reg;
    assign x_o   = x_reg;
    assign y_o   = y_reg;
    assign z_o   = z_reg;

endmodule

// ----- sv/iq_instantaneous_frequency.sv -----
// Top level: FM polar discriminator, conj(previous) * current, CORDIC arctangent.
//
// Input channel s_*: one complex sample per transaction, s_tlast marks the last
// sample of a block. Output channel m_*: phase steps scaled so that
// 2^(ANGLE_WIDTH-1) stands for pi. The first sample of a block gives no result.
// The last sample gives its phase step, then a zero result with m_tlast high.
// A single-sample block gives only the closing result.
// A result reaches m_tvalid through three front stages (product, sum, quadrant
// fold, the first one loading at the accepting edge), one cell per CORDIC step
// and the output register.
// Throughput is one sample per cycle while the output side does not stall; a
// sample that ends a block with a held predecessor owes two results, and the
// chain holds while the output register hands over the first of them.
// The whole pipeline moves on one shared enable: when the output register
// holds a result that m_tready does not take, or a phase step with its closing
// result still behind it, the chain holds and s_tready drops. Reset clears the
// held sample and all slot valid flags; the next sample after reset starts a
// new block.
module iq_instantaneous_frequency #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int ANGLE_WIDTH  = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    // sample_i, sample_q
    input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]       s_tdata,
    input  logic                                      s_tlast,
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    // phase_step
    output logic [((ANGLE_WIDTH+7)/8)*8-1:0]          m_tdata,
    output logic                                      m_tlast
);

    localparam int W    = 2 * SAMPLE_WIDTH + 3;
    localparam int ZW   = ifreq_pkg::Z_WIDTH;
    localparam int SH   = 32 - ANGLE_WIDTH;
    localparam int M_W  = ((ANGLE_WIDTH + 7) / 8) * 8;
    localparam logic signed [ZW-1:0] ROUND_HALF = ZW'(1) <<< (SH - 1);

    logic                         adv;
    logic                         accept;

    ifreq_pkg::ctl_t              ctl_w [CORDIC_STEPS+1];
    logic signed [W-1:0]          x_w   [CORDIC_STEPS+1];
    logic signed [W-1:0]          y_w   [CORDIC_STEPS+1];
    logic signed [ZW-1:0]         z_w   [CORDIC_STEPS+1];

    ifreq_pkg::ctl_t              tail_ctl;
    logic signed [ZW-1:0]         z_round;

    logic                         ob_phase_reg, ob_phase_next;
    logic                         ob_close_reg, ob_close_next;
    logic [ANGLE_WIDTH-1:0]       ob_angle_reg, ob_angle_next;

    // Advance when the output register is empty or hands over its final result.
    assign adv = !(ob_phase_reg || ob_close_reg)
               || (m_tready && (ob_phase_reg != ob_close_reg));
    assign s_tready = adv;
    assign accept   = s_tvalid && s_tready;

    ifreq_front #(
        .S (SAMPLE_WIDTH),
        .W (W)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (adv),
        .accept  (accept),
        .cur_i   (s_tdata[SAMPLE_WIDTH-1:0]),
        .cur_q   (s_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]),
        .cur_end (s_tlast),
        .ctl_o   (ctl_w[0]),
        .x_o     (x_w[0]),
        .y_o     (y_w[0]),
        .z_o     (z_w[0])
    );

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cell
        ifreq_cordic_cell #(
            .W     (W),
            .SHIFT (k)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (adv),
            .ctl_i   (ctl_w[k]),
            .x_i     (x_w[k]),
            .y_i     (y_w[k]),
            .z_i     (z_w[k]),
            .ctl_o   (ctl_w[k+1]),
            .x_o     (x_w[k+1]),
            .y_o     (y_w[k+1]),
            .z_o     (z_w[k+1])
        );
    end

    assign tail_ctl = ctl_w[CORDIC_STEPS];
    assign z_round  = z_w[CORDIC_STEPS] + ROUND_HALF;

    always_comb begin
        ob_phase_next = ob_phase_reg;
        ob_close_next = ob_close_reg;
        ob_angle_next = ob_angle_reg;
        priority if (adv) begin
            ob_phase_next = tail_ctl.valid && tail_ctl.phase;
            ob_close_next = tail_ctl.valid && tail_ctl.close;
            ob_angle_next = tail_ctl.zero ? '0 : z_round[31:SH];
        end else if (m_tvalid && m_tready) begin
            // phase step leaves first, the closing result stays
            ob_phase_next = 1'b0;
        end else begin
            // hold while the receiver stalls
            ob_phase_next = ob_phase_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ob_phase_reg <= 1'b0;
            ob_close_reg <= 1'b0;
        end else begin
            ob_phase_reg <= ob_phase_next;
            ob_close_reg <= ob_close_next;
        end
    end

    always_ff @(posedge aclk) begin
        ob_angle_reg <= ob_angle_next;
    end

    assign m_tvalid = ob_phase_reg || ob_close_reg;
    assign m_tlast  = !ob_phase_reg && ob_close_reg;
    assign m_tdata  = ob_phase_reg ? M_W'(ob_angle_reg) : '0;

    a_close_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && ob_phase_reg && ob_close_reg |=> m_tvalid && m_tlast)
        else $error("closing result did not follow the phase step");

    a_stall_only_on_output: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && (!m_tready || (ob_phase_reg && ob_close_reg)))
        else $error("input stalled without a waiting result");

    a_zero_product: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && tail_ctl.valid && tail_ctl.phase && tail_ctl.zero
        |=> ob_phase_reg && m_tdata == '0)
        else $error("zero product gave a nonzero phase step");

endmodule

// ----- tb/phase_step_checker.sv -----
// Channel monitor that predicts and checks the phase step results of the discriminator.
`timescale 1ns / 100ps

module phase_step_checker #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int ANGLE_WIDTH  = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    // sample_i, sample_q
    input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] s_tdata,
    input  logic                                s_tlast,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    // phase_step
    input  logic [((ANGLE_WIDTH+7)/8)*8-1:0]    m_tdata,
    input  logic                                m_tlast,
    output int                                  mismatches,
    output int                                  owed,
    output int                                  steps_seen,
    output int                                  closes_seen
);

    typedef struct packed {
        logic [ANGLE_WIDTH-1:0] phase_step;
        logic                   last_result;
    } phase_result_t;

    phase_result_t owed_results[$];

    // held sample of the current block
    longint held_i;
    longint held_q;
    logic   have_held;

    // Vectoring CORDIC on the exact products; 2^31 stands for pi in the accumulator.
    function automatic logic [ANGLE_WIDTH-1:0] cordic_phase(input longint y_in,
                                                            input longint x_in);
        longint x, y, z, xs, ys, t;
        x = x_in;
        y = y_in;
        z = 0;
        if (x == 0 && y == 0)
            return '0;
        // fold the left half plane onto the right one
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y;
                y = -t;
                z = longint'(ifreq_pkg::QUARTER_TURN);
            end else begin
                x = -y;
                y = t;
                z = -longint'(ifreq_pkg::QUARTER_TURN);
            end
        end
        for (int k = 0; k < CORDIC_STEPS && k < ifreq_pkg::ATAN_LEN; k++) begin
            xs = x >>> k;
            ys = y >>> k;
            if (y > 0) begin
                x = x + ys;
                y = y - xs;
                z = z + longint'(ifreq_pkg::ATAN_TAB[k]);
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - longint'(ifreq_pkg::ATAN_TAB[k]);
            end
        end
        // round half up to the output width, then wrap
        z = (z + (longint'(1) <<< (31 - ANGLE_WIDTH))) >>> (32 - ANGLE_WIDTH);
        return z[ANGLE_WIDTH-1:0];
    endfunction

    always @(posedge aclk) begin : track
        longint        ci, cq, t_im, t_re;
        phase_result_t want;
        if (!aresetn) begin
            owed_results.delete();
            held_i      = 0;
            held_q      = 0;
            have_held   = 1'b0;
            mismatches  = 0;
            steps_seen  = 0;
            closes_seen = 0;
        end else begin
            // check first: a sample taken at this edge cannot have a result yet
            if (m_tvalid && m_tready) begin
                if (m_tlast)
                    closes_seen++;
                else
                    steps_seen++;
                if (owed_results.size() == 0) begin
                    $display("%0t: unexpected result: expected none, got step %0d last %0b",
                             $time, $signed(m_tdata[ANGLE_WIDTH-1:0]), m_tlast);
                    mismatches++;
                end else begin
                    want = owed_results.pop_front();
                    if (m_tdata[ANGLE_WIDTH-1:0] !== want.phase_step) begin
                        $display("%0t: phase_step mismatch: expected %0d, got %0d",
                                 $time, $signed(want.phase_step),
                                 $signed(m_tdata[ANGLE_WIDTH-1:0]));
                        mismatches++;
                    end
                    if (m_tlast !== want.last_result) begin
                        $display("%0t: last_result mismatch: expected %0b, got %0b",
                                 $time, want.last_result, m_tlast);
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                ci = longint'($signed(s_tdata[SAMPLE_WIDTH-1:0]));
                cq = longint'($signed(s_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]));
                if (have_held) begin
                    // conj(held) * current
                    t_im = held_i * cq - ci * held_q;
                    t_re = ci * held_i + cq * held_q;
                    want.phase_step  = cordic_phase(t_im, t_re);
                    want.last_result = 1'b0;
                    owed_results.push_back(want);
                end
                if (s_tlast) begin
                    want.phase_step  = '0;
                    want.last_result = 1'b1;
                    owed_results.push_back(want);
                    held_i    = 0;
                    held_q    = 0;
                    have_held = 1'b0;
                end else begin
                    held_i    = ci;
                    held_q    = cq;
                    have_held = 1'b1;
                end
            end
        end
        owed = owed_results.size();
    end

endmodule

// ----- tb/tb.sv -----
// Testbench top: drives samples and output back-pressure, gives the verdict.
`timescale 1ns / 100ps

module tb;

    localparam int SAMPLE_WIDTH = 16;
    localparam int ANGLE_WIDTH  = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int S_DATA_W     = ((2*SAMPLE_WIDTH+7)/8)*8;
    localparam int M_DATA_W     = ((ANGLE_WIDTH+7)/8)*8;
    localparam int IDLE_LIMIT   = 5000;
    localparam int HOLD_CYCLES  = 150;

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic                s_tlast;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tlast;

    int mismatches;
    int owed;
    int steps_seen;
    int closes_seen;

    int samples_sent;
    int blocks_sent;
    int single_blocks;
    int rx_holds;
    int idle_cycles;
    bit tx_no_gap;
    bit rx_no_gap;
    bit rx_hold_req;

    iq_instantaneous_frequency #(
        .SAMPLE_WIDTH(SAMPLE_WIDTH),
        .ANGLE_WIDTH (ANGLE_WIDTH),
        .CORDIC_STEPS(CORDIC_STEPS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    phase_step_checker #(
        .SAMPLE_WIDTH(SAMPLE_WIDTH),
        .ANGLE_WIDTH (ANGLE_WIDTH),
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .mismatches (mismatches),
        .owed       (owed),
        .steps_seen (steps_seen),
        .closes_seen(closes_seen)
    );

    initial aclk = 1'b0;
    always #6 aclk = ~aclk;

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic send_sample(input int si, input int sq, input logic end_of_block);
        int gap;
        gap = tx_no_gap ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {sq[SAMPLE_WIDTH-1:0], si[SAMPLE_WIDTH-1:0]};
        s_tlast  <= end_of_block;
        do @(posedge aclk); while (!s_tready);
        samples_sent++;
        if (end_of_block)
            blocks_sent++;
        @(negedge aclk);
    endtask

    function automatic int rand_sample();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return int'($urandom);
        if (r < 8)
            return int'($urandom_range(0, 32)) - 16;
        case ($urandom_range(0, 4))
            0:       return 32767;
            1:       return -32768;
            2:       return 0;
            3:       return -1;
            default: return 1;
        endcase
    endfunction

    task automatic send_block();
        int len;
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            len = 1;
        else if (r == 1)
            len = 2;
        else
            len = $urandom_range(3, 40);
        if (len == 1)
            single_blocks++;
        for (int n = 0; n < len; n++)
            send_sample(rand_sample(), rand_sample(), n == len - 1);
    endtask

    // Output side: random ready gaps, bursts, and one long hold on request.
    initial begin : receiver
        int gap;
        m_tready = 1'b0;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            if (rx_hold_req)
                gap = HOLD_CYCLES;
            else
                gap = rx_no_gap ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                rx_holds++;
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            @(negedge aclk);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tlast     = 1'b0;
        aresetn     = 1'b0;
        tx_no_gap   = 1'b0;
        rx_no_gap   = 1'b0;
        rx_hold_req = 1'b0;
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // single-sample block: closing result only
        send_sample(0, 0, 1'b1);
        // zero step, four positive quarter turns, then a half turn that wraps
        send_sample(16384, 0, 1'b0);
        send_sample(16384, 0, 1'b0);
        send_sample(0, 16384, 1'b0);
        send_sample(-16384, 0, 1'b0);
        send_sample(0, -16384, 1'b0);
        send_sample(16384, 0, 1'b0);
        send_sample(-16384, 0, 1'b1);
        // zero product from a zero held sample
        send_sample(0, 0, 1'b0);
        send_sample(12345, -2000, 1'b0);
        // full-scale corners
        send_sample(32767, 32767, 1'b0);
        send_sample(-32768, -32768, 1'b0);
        send_sample(-32768, 32767, 1'b0);
        send_sample(32767, -32768, 1'b1);
        send_sample(-32768, 0, 1'b1);
        send_sample(32767, -1, 1'b0);
        send_sample(-1, 32767, 1'b0);
        send_sample(-1, -1, 1'b0);
        send_sample(1, 0, 1'b1);

        while (samples_sent < 450)
            send_block();

        tx_no_gap = 1'b1;
        rx_no_gap = 1'b1;
        while (samples_sent < 750)
            send_block();

        // keep offering samples while the output side holds off
        rx_hold_req = 1'b1;
        while (samples_sent < 950)
            send_block();
        tx_no_gap = 1'b0;
        rx_no_gap = 1'b0;

        // drain before going on
        s_tvalid <= 1'b0;
        wait (owed == 0);
        @(negedge aclk);

        while (samples_sent < 1350)
            send_block();

        s_tvalid <= 1'b0;
        wait (owed == 0);
        repeat (CORDIC_STEPS + 12) @(negedge aclk);

        $display("Sent %0d samples in %0d blocks (%0d single-sample), %0d long output stalls.",
                 samples_sent, blocks_sent, single_blocks, rx_holds);
        $display("Checked %0d phase steps and %0d closing results, %0d mismatches.",
                 steps_seen, closes_seen, mismatches);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
